[hw/rtl/u8r_pkg.sv]
package u8r_pkg;

  localparam int unsigned MAX_BURST = 8;
  localparam int unsigned CNT_W     = $clog2(MAX_BURST + 1);
  localparam int unsigned HELD_MAX  = 3;

  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      str_end;
  } u8r_burst_t;

  function automatic logic [7:0] latin1_hi(input logic [7:0] b);
    latin1_hi = LEAD2_CODE | {6'd0, b[7:6]};
  endfunction

  function automatic logic [7:0] latin1_lo(input logic [7:0] b);
    latin1_lo = CONT_CODE | (b & LOW6_MASK);
  endfunction

endpackage

[hw/rtl/utf8_repair_latin1_fallback_core.sv]
// utf8 repair with latin-1 fallback
// in_* channel: one raw byte per beat, in_tlast marks the final byte of a string.
// out_* channel: repaired utf-8 bytes, one per beat; out_tuser marks the last
// byte caused by one input beat, out_tlast the final byte of the whole string.
// valid multi-byte sequences are held until complete and then pass unchanged;
// broken ones, stray continuation bytes and 0xf8..0xff go out re-encoded as
// two-byte utf-8 of their latin-1 value. held bytes are flushed at end of string.
// an input beat that only holds a byte yields no output beat.
// an accepted input beat goes into the input register and, when the output
// side is free, from there into the output buffer, where its first beat is valid.
// throughput: an input beat yields 0 to 8 output beats from the output buffer;
// holding beats bypass the output buffer. plain ascii streams at one byte per
// cycle while out_tready stays high. the output buffer takes a new run
// in the cycle its final beat is taken.
// stall: when out_tready is low the run waits in the output buffer, the input
// register fills and in_tready drops; nothing is lost.
// reset: synchronous active-low rst_n clears the held-sequence state and
// empties both registers.
module utf8_repair_latin1_fallback_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // in_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tuser,  // run_last
  output logic       out_tlast   // string_last
);
  import u8r_pkg::*;

  logic       vld_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic       advance;
  logic       can_load;
  logic       load;
  u8r_burst_t burst;

  assign advance   = vld_r && ((burst.count == '0) || can_load);
  assign load      = advance && (burst.count != '0);
  assign in_tready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  u8r_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_byte (byte_r),
    .item_end  (end_r),
    .advance   (advance),
    .burst     (burst)
  );

  u8r_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .burst      (burst),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[hw/rtl/u8r_step.sv]
module u8r_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        item_byte,
  input  logic              item_end,
  input  logic              advance,
  output u8r_pkg::u8r_burst_t burst
);
  import u8r_pkg::*;

  logic [7:0]       held_r [HELD_MAX];
  logic [7:0]       held_nxt [HELD_MAX];
  logic [1:0]       cnt_r, cnt_nxt;
  logic [2:0]       seq_r, seq_nxt;

  logic [MAX_BURST-1:0][7:0] ob;
  logic [CNT_W-1:0]          n;
  logic                      cont;

  always_comb begin
    ob       = '0;
    n        = '0;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    seq_nxt  = seq_r;
    cont     = (item_byte & CONT_MASK) == CONT_CODE;

    if (cnt_r != 2'd0 && cont) begin
      if ({1'b0, cnt_r} + 3'd1 >= seq_r) begin
        // complete sequence passes unchanged
        for (int i = 0; i < HELD_MAX; i++) begin
          if (2'(i) < cnt_r) begin
            ob[n[2:0]] = held_r[i];
            n = n + 1'b1;
          end
        end
        ob[n[2:0]] = item_byte;
        n = n + 1'b1;
        cnt_nxt = 2'd0;
        seq_nxt = SEQ_NONE;
      end else if (cnt_r < 2'd3) begin
        held_nxt[cnt_r] = item_byte;
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        for (int i = 0; i < HELD_MAX; i++) begin
          if (2'(i) < cnt_r) begin
            ob[n[2:0]] = latin1_hi(held_r[i]);
            n = n + 1'b1;
            ob[n[2:0]] = latin1_lo(held_r[i]);
            n = n + 1'b1;
          end
        end
        ob[n[2:0]] = latin1_hi(item_byte);
        n = n + 1'b1;
        ob[n[2:0]] = latin1_lo(item_byte);
        n = n + 1'b1;
        cnt_nxt = 2'd0;
        seq_nxt = SEQ_NONE;
      end
    end else begin
      // broken sequence or nothing held: flush held bytes converted, then take the new byte
      for (int i = 0; i < HELD_MAX; i++) begin
        if (2'(i) < cnt_r) begin
          ob[n[2:0]] = latin1_hi(held_r[i]);
          n = n + 1'b1;
          ob[n[2:0]] = latin1_lo(held_r[i]);
          n = n + 1'b1;
        end
      end
      cnt_nxt = 2'd0;
      seq_nxt = SEQ_NONE;
      if ((item_byte & ASCII_MASK) == 8'h00) begin
        ob[n[2:0]] = item_byte;
        n = n + 1'b1;
      end else if ((item_byte & LEAD2_MASK) == LEAD2_CODE) begin
        held_nxt[0] = item_byte;
        cnt_nxt = 2'd1;
        seq_nxt = SEQ_TWO;
      end else if ((item_byte & LEAD3_MASK) == LEAD3_CODE) begin
        held_nxt[0] = item_byte;
        cnt_nxt = 2'd1;
        seq_nxt = SEQ_THREE;
      end else if ((item_byte & LEAD4_MASK) == LEAD4_CODE) begin
        held_nxt[0] = item_byte;
        cnt_nxt = 2'd1;
        seq_nxt = SEQ_FOUR;
      end else begin
        ob[n[2:0]] = latin1_hi(item_byte);
        n = n + 1'b1;
        ob[n[2:0]] = latin1_lo(item_byte);
        n = n + 1'b1;
      end
    end

    // end of string: flush whatever is still held
    if (item_end) begin
      for (int i = 0; i < HELD_MAX; i++) begin
        if (2'(i) < cnt_nxt) begin
          ob[n[2:0]] = latin1_hi(held_nxt[i]);
          n = n + 1'b1;
          ob[n[2:0]] = latin1_lo(held_nxt[i]);
          n = n + 1'b1;
        end
      end
      cnt_nxt = 2'd0;
      seq_nxt = SEQ_NONE;
    end
  end

  assign burst.bytes   = ob;
  assign burst.count   = n;
  assign burst.str_end = item_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      seq_r <= SEQ_NONE;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_r <= held_nxt;
    end
  end

endmodule

[hw/rtl/u8r_outbuf.sv]
module u8r_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  u8r_pkg::u8r_burst_t burst,
  output logic                can_load,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // out_byte
  output logic                out_tuser,  // run_last
  output logic                out_tlast   // string_last
);
  import u8r_pkg::*;

  logic [MAX_BURST-1:0][7:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic                      end_r, end_nxt;
  logic                      beat;
  logic                      final_beat;

  assign final_beat = rem_r == CNT_W'(1);
  assign beat       = out_tvalid && out_tready;
  assign can_load   = (rem_r == '0) || (final_beat && out_tready);

  assign out_tvalid = rem_r != '0;
  assign out_tdata  = buf_r[0];
  assign out_tuser  = final_beat;
  assign out_tlast  = final_beat && end_r;

  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    end_nxt = end_r;
    if (load) begin
      buf_nxt = burst.bytes;
      rem_nxt = burst.count;
      end_nxt = burst.str_end;
    end else if (beat) begin
      buf_nxt = buf_r >> 8;
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    end_r <= end_nxt;
  end

endmodule

[sim/utf8_repair_checker.sv]
module utf8_repair_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // in_end
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // out_byte
  input  logic       out_tuser,  // run_last
  input  logic       out_tlast,  // string_last
  output int         errors,
  output int         pending
);
  import u8r_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_last;
  } out_beat_t;

  out_beat_t  repaired_q[$];

  logic [7:0] held [HELD_MAX];
  logic [1:0] held_n;
  logic [2:0] seq_len;

  logic [7:0] burst [MAX_BURST];
  int         burst_n;

  task automatic push_byte(input logic [7:0] b);
    if (burst_n < MAX_BURST) begin
      burst[burst_n] = b;
      burst_n++;
    end
  endtask

  // latin-1 value re-encoded as two-byte utf-8
  task automatic push_latin1(input logic [7:0] b);
    push_byte({2'b11, 4'd0, b[7:6]});
    push_byte({2'b10, b[5:0]});
  endtask

  task automatic flush_held();
    int i;
    for (i = 0; i < int'(held_n); i++) push_latin1(held[i]);
    held_n  = 2'd0;
    seq_len = SEQ_NONE;
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic e);
    int        i;
    out_beat_t ob;
    burst_n = 0;
    if (held_n != 2'd0 && (b & CONT_MASK) == CONT_CODE) begin
      if (int'(held_n) + 1 >= int'(seq_len)) begin
        for (i = 0; i < int'(held_n); i++) push_byte(held[i]);
        push_byte(b);
        held_n  = 2'd0;
        seq_len = SEQ_NONE;
      end else if (held_n < 2'd3) begin
        held[held_n] = b;
        held_n++;
      end else begin
        flush_held();
        push_latin1(b);
      end
    end else begin
      if (held_n != 2'd0) flush_held();
      if ((b & ASCII_MASK) == 8'h00) begin
        push_byte(b);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        held[0] = b; held_n = 2'd1; seq_len = SEQ_TWO;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        held[0] = b; held_n = 2'd1; seq_len = SEQ_THREE;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        held[0] = b; held_n = 2'd1; seq_len = SEQ_FOUR;
      end else begin
        push_latin1(b);
      end
    end
    if (e) flush_held();
    for (i = 0; i < burst_n; i++) begin
      ob.data     = burst[i];
      ob.run_last = (i == burst_n - 1);
      ob.str_last = (i == burst_n - 1) && e;
      repaired_q.push_back(ob);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      held_n  = 2'd0;
      seq_len = SEQ_NONE;
      errors  = 0;
      repaired_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (repaired_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %02h/%b/%b",
                   $time, out_tdata, out_tuser, out_tlast);
          errors++;
        end else begin
          want = repaired_q.pop_front();
          if (want !== {out_tdata, out_tuser, out_tlast}) begin
            $display("%0t: beat mismatch, expected %02h/%b/%b, got %02h/%b/%b",
                     $time, want.data, want.run_last, want.str_last,
                     out_tdata, out_tuser, out_tlast);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_beat(in_tdata, in_tlast);
    end
    pending = repaired_q.size();
  end

endmodule

[sim/testbench.sv]
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 20;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       calm       = 1'b0;

  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  int errors;
  int pending;
  int cycles = 0;
  int sent   = 0;

  utf8_repair_latin1_fallback_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_repair_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("utf8_repair_latin1_fallback_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    calm <= (sent >= 150 && sent < 260);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic rand_end();
    return $urandom_range(0, 19) == 0;
  endfunction

  function automatic logic [7:0] rand_cont();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] rand_lead(input int len);
    case (len)
      2: return {3'b110, 5'($urandom_range(0, 31))};
      3: return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  initial begin
    int kind;
    int len;
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero byte and top ascii
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // complete 2-, 3- and 4-byte sequences
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // stray continuation, invalid high byte
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    // three held bytes broken by an invalid byte
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'hFF, 1'b0);
    // broken by ascii, broken by a new lead
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC3, 1'b0);
    // end of string with bytes held
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hDF, 1'b1);

    while (sent < 425) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) send_byte({1'b0, 7'($urandom_range(0, 127))}, rand_end());
      end else if (kind < 75) begin
        len = $urandom_range(2, 4);
        send_byte(rand_lead(len), rand_end());
        for (k = 1; k < len; k++) send_byte(rand_cont(), rand_end());
      end else if (kind < 87) begin
        len = $urandom_range(3, 4);
        send_byte(rand_lead(len), rand_end());
        len = $urandom_range(1, len - 2);
        for (k = 0; k < len; k++) send_byte(rand_cont(), rand_end());
      end else begin
        send_byte(8'($urandom_range(0, 255)), rand_end());
      end
    end
    send_byte(8'h41, 1'b1);
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("utf8_repair_latin1_fallback_core test passed");
    end else begin
      $display("utf8_repair_latin1_fallback_core test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/u8r_pkg.sv
hw/rtl/u8r_step.sv
hw/rtl/u8r_outbuf.sv
hw/rtl/utf8_repair_latin1_fallback_core.sv
sim/utf8_repair_checker.sv
sim/testbench.sv
